[rtl/pdl_pkg.sv]
// ----------------------------------------------------------------------------
// pdl_pkg: shared types and constants for the percent decoder
// Holds the queue entry type, the front-end write bundle, the decode phase
// enum and the digit reduction function used by the front end.
// ----------------------------------------------------------------------------
package pdl_pkg;

  localparam logic [7:0] PctChar   = 8'h25;
  localparam logic [7:0] NineChar  = 8'h39;
  localparam logic [7:0] LowerA    = 8'h61;
  localparam logic [7:0] LowerZ    = 8'h7A;
  localparam logic [7:0] UpperA    = 8'h41;
  localparam logic [7:0] UpperZ    = 8'h5A;
  localparam logic [7:0] CaseBit   = 8'h20;
  localparam logic [7:0] LeadByte  = 8'hC3;
  localparam logic [7:0] LatinLow  = 8'h80;
  localparam logic [7:0] LatinHigh = 8'h9E;
  localparam logic [7:0] DigitOff  = 8'd48;
  localparam logic [7:0] AlphaOff  = 8'd55;

  // Decode phase of the front end.
  typedef enum logic [1:0] {
    PH_PLAIN  = 2'd0,
    PH_PCT    = 2'd1,
    PH_DIGIT  = 2'd2
  } phase_e;

  // One decoded byte waiting to be case-folded.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } entry_t;

  // Writes from the front end into the queue for one accepted item.
  typedef struct packed {
    logic [1:0] count;
    entry_t     e0;
    entry_t     e1;
  } wr_t;

  // Upper-case a-z, then subtract the ASCII offset of a hex digit.
  function automatic logic [7:0] reduce_digit(input logic [7:0] d);
    logic [7:0] u;
    u = d;
    if (d >= LowerA && d <= LowerZ) u = d - CaseBit;
    return (u <= NineChar) ? (u - DigitOff) : (u - AlphaOff);
  endfunction

endpackage

[rtl/pdl_front.sv]
// ----------------------------------------------------------------------------
// pdl_front: percent-escape decoder
// Accepts raw bytes, tracks the escape phase, and hands zero, one or two
// decoded bytes per item to the queue. Drops the rest of a name after a
// decoded zero.
// ----------------------------------------------------------------------------
module pdl_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [7:0]     in_byte_i,
  input  logic           in_last_i,
  output pdl_pkg::wr_t   wr_o
);
  import pdl_pkg::*;

  phase_e     phase_q, phase_d;
  logic [7:0] held_q, held_d;
  logic       drop_q, drop_d;
  logic [7:0] red;
  logic [7:0] pair;

  assign red  = reduce_digit(in_byte_i);
  assign pair = {held_q[3:0], 4'h0} + red;

  // Next phase, held digit and drop flag.
  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    drop_d  = drop_q;
    if (accept_i) begin
      if (drop_q) begin
        if (in_last_i) drop_d = 1'b0;
      end else begin
        unique case (phase_q)
          PH_PCT: begin
            if (in_last_i) begin
              phase_d = PH_PLAIN;
            end else begin
              phase_d = PH_DIGIT;
              held_d  = red;
            end
          end
          PH_DIGIT: begin
            phase_d = PH_PLAIN;
            drop_d  = (pair == 8'h00) && !in_last_i;
          end
          default: begin
            if (in_byte_i == PctChar && !in_last_i) begin
              phase_d = PH_PCT;
            end else begin
              phase_d = PH_PLAIN;
              drop_d  = (in_byte_i == 8'h00) && !in_last_i;
            end
          end
        endcase
      end
    end
  end

  // Queue writes for the accepted item.
  always_comb begin
    wr_o.count   = 2'd0;
    wr_o.e0.data = in_byte_i;
    wr_o.e0.last = in_last_i;
    wr_o.e1.data = in_byte_i;
    wr_o.e1.last = 1'b1;
    if (accept_i && !drop_q) begin
      unique case (phase_q)
        PH_PCT: begin
          // A lone escape before the last byte passes through as two bytes.
          if (in_last_i) begin
            wr_o.count   = 2'd2;
            wr_o.e0.data = PctChar;
            wr_o.e0.last = 1'b0;
          end
        end
        PH_DIGIT: begin
          wr_o.count   = 2'd1;
          wr_o.e0.data = pair;
          wr_o.e0.last = in_last_i || (pair == 8'h00);
        end
        default: begin
          if (!(in_byte_i == PctChar && !in_last_i)) begin
            wr_o.count   = 2'd1;
            wr_o.e0.last = in_last_i || (in_byte_i == 8'h00);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PLAIN;
      drop_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      drop_q  <= drop_d;
    end
  end

  // The held digit is payload and is always rewritten before use.
  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

endmodule

[rtl/pdl_queue.sv]
// ----------------------------------------------------------------------------
// pdl_queue: decoupling queue between decoder and folder
// Takes up to two entries per cycle; gives one per cycle from the head on rd_i.
// Depth must be a power of two.
// ----------------------------------------------------------------------------
module pdl_queue #(
  parameter int Depth = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pdl_pkg::wr_t             wr_i,
  input  logic                     rd_i,
  output pdl_pkg::entry_t          head_o,
  output logic                     avail_o,
  output logic [$clog2(Depth+1)-1:0] level_o
);
  import pdl_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int LvlW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [LvlW-1:0]   level_q;
  logic [PtrW-1:0]   wr_ptr1;
  logic              do_rd;

  assign wr_ptr1 = wr_ptr_q + PtrW'(1);
  assign do_rd   = rd_i && (level_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign avail_o = (level_q != '0);
  assign level_o = level_q;

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (wr_i.count != 2'd0) mem_q[wr_ptr_q] <= wr_i.e0;
    if (wr_i.count == 2'd2) mem_q[wr_ptr1]  <= wr_i.e1;
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(wr_i.count);
      if (do_rd) rd_ptr_q <= rd_ptr_q + PtrW'(1);
      level_q  <= level_q + LvlW'(wr_i.count) - LvlW'(do_rd);
    end
  end

endmodule

[rtl/pdl_back.sv]
// ----------------------------------------------------------------------------
// pdl_back: case folder and result register
// Folds ASCII upper case and Latin-1 letters after a 0xC3 lead byte, and
// holds the result until it is popped.
// ----------------------------------------------------------------------------
module pdl_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pdl_pkg::entry_t head_i,
  input  logic            avail_i,
  output logic            take_o,
  input  logic            pop_i,
  output logic            empty_o,
  output logic [7:0]      out_byte_o,
  output logic            out_last_o
);
  import pdl_pkg::*;

  logic       valid_q, valid_d;
  logic       prefix_q, prefix_d;
  logic [7:0] byte_q, byte_d;
  logic       last_q, last_d;
  logic       is_zero;

  assign is_zero = (head_i.data == 8'h00);
  assign take_o  = avail_i && (!valid_q || pop_i);

  // Fold the head entry and track the lead-byte prefix.
  always_comb begin
    byte_d   = head_i.data;
    prefix_d = prefix_q;
    priority if (is_zero) begin
      prefix_d = 1'b0;
    end else if (prefix_q) begin
      prefix_d = 1'b0;
      if (head_i.data >= LatinLow && head_i.data <= LatinHigh) begin
        byte_d = head_i.data | CaseBit;
      end
    end else if (head_i.data == LeadByte) begin
      prefix_d = 1'b1;
    end else if (head_i.data >= UpperA && head_i.data <= UpperZ) begin
      byte_d = head_i.data | CaseBit;
    end
    if (head_i.last) prefix_d = 1'b0;
    last_d = head_i.last;
  end

  // Result valid flag.
  always_comb begin
    valid_d = valid_q;
    if (take_o) valid_d = 1'b1;
    else if (pop_i) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      prefix_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (take_o) prefix_q <= prefix_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      byte_q <= byte_d;
      last_q <= last_d;
    end
  end

  assign empty_o    = !valid_q;
  assign out_byte_o = byte_q;
  assign out_last_o = last_q;

endmodule

[rtl/percent_decode_latin_lowercase_top.sv]
// ----------------------------------------------------------------------------
// percent_decode_latin_lowercase_top: streaming percent decoder and folder
// Decodes percent escapes in a byte stream of names and lower-cases the
// result, ASCII and Latin-1 letters encoded after a 0xC3 lead byte.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle on push/full and delivers decoded
// bytes on empty/pop. An item normally yields one result, held first in
// the queue and then in the result register; an escape yields one result
// on its third byte, and a '%' directly before the last byte of a name
// yields two. The front decoder writes into a small queue that drains one
// entry per cycle into the case folder, so full rises only when the queue
// cannot take two more entries, which happens when two-result items arrive
// faster than the folder can drain the extra entries, or while results are
// not popped. A decoded zero is delivered with out_last set and the rest
// of that name is dropped.
module percent_decode_latin_lowercase_top #(
  parameter int QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);
  import pdl_pkg::*;

  localparam int LvlW = $clog2(QueueDepth + 1);

  wr_t             wr;
  entry_t          head;
  logic            avail;
  logic            take;
  logic            accept;
  logic [LvlW-1:0] level;

  // Accept only when the queue has room for two entries.
  assign full   = (level >= LvlW'(QueueDepth - 1));
  assign accept = push && !full;

  pdl_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_byte_i (in_byte_i),
    .in_last_i (in_last_i),
    .wr_o      (wr)
  );

  pdl_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr),
    .rd_i    (take),
    .head_o  (head),
    .avail_o (avail),
    .level_o (level)
  );

  pdl_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .avail_i    (avail),
    .take_o     (take),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_byte_o (out_byte_o),
    .out_last_o (out_last_o)
  );

  // The queue never holds more entries than it has slots.
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level <= LvlW'(QueueDepth))
    else $error("queue level exceeds depth");

  // A decoded zero always ends the name.
  a_zero_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_byte_o == 8'h00) |-> out_last_o)
    else $error("zero result without last flag");

  // A waiting queue entry is loaded into an empty result register in the next cycle.
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (avail && empty) |=> !empty)
    else $error("result register not refilled from queue");

endmodule

[tb/tb_percent_decode_latin_lowercase_top.sv]
// ----------------------------------------------------------------------------
// tb_percent_decode_latin_lowercase_top: self-checking bench for the decoder
// Pushes names byte by byte through the queue-style input, pops decoded
// bytes at random rates and checks each one against hand-written results
// or a behavioral decoder kept in step with every accepted item. A short
// table of directed names runs first, followed by random names built from
// escapes, lead bytes, letters and noise.
// ----------------------------------------------------------------------------
module tb_percent_decode_latin_lowercase_top;
  import pdl_pkg::*;

  localparam int NumItems   = 1950;
  localparam int CalmItems  = 300;
  localparam int DrainEvery = 500;

  // One row of directed stimulus; typed rows carry their own results.
  typedef struct {
    logic [7:0] b;
    logic       last;
    bit         typed;
    int         n;
    entry_t     r0;
    entry_t     r1;
  } stim_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_byte_i = 8'h00;
  logic       in_last_i = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_byte_o;
  logic       out_last_o;

  // Decoder state mirrored by the bench.
  phase_e     dec_phase = PH_PLAIN;
  logic [7:0] held_digit_q = 8'h00;
  logic       lead_seen = 1'b0;
  logic       skipping = 1'b0;
  entry_t     folded_q[$];
  entry_t     expected_q[$];
  entry_t     want;

  int mismatch_cnt = 0;
  int live_items = 0;
  int stall_left = 0;
  bit idle_on = 1'b1;

  percent_decode_latin_lowercase_top u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_byte_i (in_byte_i),
    .in_last_i (in_last_i),
    .empty     (empty),
    .pop       (pop),
    .out_byte_o(out_byte_o),
    .out_last_o(out_last_o)
  );

  always #5 clk_i = ~clk_i;

  // Upper-case a letter, then take off the ASCII offset without any hex check.
  function automatic logic [7:0] digit_weight(input logic [7:0] d);
    logic [7:0] u;
    u = (d >= LowerA && d <= LowerZ) ? (d & ~CaseBit) : d;
    return (u <= NineChar) ? u - DigitOff : u - AlphaOff;
  endfunction

  // Case-fold one decoded byte into the result list; returns 1 on a terminator.
  function automatic bit fold_byte(input logic [7:0] b, input logic last);
    logic [7:0] v;
    bit         ended;
    v = b;
    ended = 1'b0;
    if (b == 8'h00) begin
      lead_seen = 1'b0;
      ended = 1'b1;
    end else if (lead_seen) begin
      lead_seen = 1'b0;
      if (b >= LatinLow && b <= LatinHigh) v = b | CaseBit;
    end else if (b == LeadByte) begin
      lead_seen = 1'b1;
    end else if (b >= UpperA && b <= UpperZ) begin
      v = b | CaseBit;
    end
    folded_q.insert(folded_q.size(), '{data: v, last: ended || last});
    return ended;
  endfunction

  // Advance the decoder by one input byte; results land in folded_q.
  task automatic predict_item(input logic [7:0] b, input logic last);
    bit ended;
    folded_q.delete();
    ended = 1'b0;
    if (skipping) begin
      if (last) skipping = 1'b0;
      return;
    end
    case (dec_phase)
      PH_PCT: begin
        if (!last) begin
          held_digit_q = digit_weight(b);
          dec_phase = PH_DIGIT;
          return;
        end
        ended = fold_byte(PctChar, 1'b0);
        if (!ended) ended = fold_byte(b, 1'b1);
      end
      PH_DIGIT: begin
        dec_phase = PH_PLAIN;
        ended = fold_byte({held_digit_q[3:0], 4'h0} + digit_weight(b), last);
      end
      default: begin
        dec_phase = PH_PLAIN;
        if (b == PctChar && !last) begin
          dec_phase = PH_PCT;
          return;
        end
        ended = fold_byte(b, last);
      end
    endcase
    if (ended || last) begin
      dec_phase = PH_PLAIN;
      held_digit_q = 8'h00;
      lead_seen = 1'b0;
    end
    if (ended && !last) skipping = 1'b1;
  endtask

  // Row whose results come from the predictor.
  function automatic stim_row_t pr(input logic [7:0] b, input logic last);
    stim_row_t row;
    row.b = b;
    row.last = last;
    row.typed = 1'b0;
    row.n = 0;
    row.r0 = '0;
    row.r1 = '0;
    return row;
  endfunction

  // Row with results written out by hand.
  function automatic stim_row_t ty(input logic [7:0] b, input logic last, input int n,
                                   input logic [7:0] d0 = 8'h00, input logic l0 = 1'b0,
                                   input logic [7:0] d1 = 8'h00, input logic l1 = 1'b0);
    stim_row_t row;
    row = pr(b, last);
    row.typed = 1'b1;
    row.n = n;
    row.r0 = '{data: d0, last: l0};
    row.r1 = '{data: d1, last: l1};
    return row;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
    if (nib < 4'd10) return 8'h30 + 8'(nib);
    return (upper ? UpperA : LowerA) + 8'(nib) - 8'd10;
  endfunction

  // Offer one item, wait for it to be taken and record what it should produce.
  task automatic send_row(input stim_row_t row);
    int gap;
    bit was_skipping;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      push <= 1'b0;
    end
    @(negedge clk_i);
    push <= 1'b1;
    in_byte_i <= row.b;
    in_last_i <= row.last;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    was_skipping = skipping;
    predict_item(row.b, row.last);
    if (!was_skipping) live_items++;
    if (row.typed) begin
      if (row.n > 0) expected_q.insert(expected_q.size(), row.r0);
      if (row.n > 1) expected_q.insert(expected_q.size(), row.r1);
    end else begin
      foreach (folded_q[i]) expected_q.insert(expected_q.size(), folded_q[i]);
    end
  endtask

  // Hold the input side until every expected byte has been popped.
  task automatic wait_drained();
    @(negedge clk_i);
    push <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  // Build one random name from tokens, sometimes cut short, and send it.
  task automatic send_name();
    logic [7:0] bytes[$];
    logic [7:0] val;
    int         len;
    int         sel;
    int         cut;
    len = $urandom_range(1, 12);
    while (bytes.size() < len) begin
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        // Plain letters of either case.
        if ($urandom_range(0, 1)) begin
          bytes.insert(bytes.size(), 8'($urandom_range(UpperA, UpperZ)));
        end else begin
          bytes.insert(bytes.size(), 8'($urandom_range(LowerA, LowerZ)));
        end
      end else if (sel < 55) begin
        // Escape with hex digits, now and then a terminator or junk digits.
        val = ($urandom_range(0, 15) == 0) ? 8'h00 : 8'($urandom);
        bytes.insert(bytes.size(), PctChar);
        if ($urandom_range(0, 7) == 0) begin
          bytes.insert(bytes.size(), 8'($urandom_range(1, 255)));
          bytes.insert(bytes.size(), 8'($urandom_range(1, 255)));
        end else begin
          bytes.insert(bytes.size(), hex_char(val[7:4], $urandom_range(0, 1)));
          bytes.insert(bytes.size(), hex_char(val[3:0], $urandom_range(0, 1)));
        end
      end else if (sel < 70) begin
        // Raw two-byte Latin-1 letter.
        bytes.insert(bytes.size(), LeadByte);
        bytes.insert(bytes.size(), 8'($urandom_range(LatinLow, 8'hBF)));
      end else if (sel < 80) begin
        // A Latin-1 letter written entirely as escapes.
        val = 8'($urandom_range(LatinLow, 8'h9F));
        bytes.insert(bytes.size(), PctChar);
        bytes.insert(bytes.size(), hex_char(LeadByte[7:4], $urandom_range(0, 1)));
        bytes.insert(bytes.size(), hex_char(LeadByte[3:0], $urandom_range(0, 1)));
        bytes.insert(bytes.size(), PctChar);
        bytes.insert(bytes.size(), hex_char(val[7:4], $urandom_range(0, 1)));
        bytes.insert(bytes.size(), hex_char(val[3:0], $urandom_range(0, 1)));
      end else begin
        bytes.insert(bytes.size(), 8'($urandom_range(1, 255)));
      end
    end
    // A cut name leaves escapes and lead bytes without their tail.
    if ($urandom_range(0, 4) == 0) begin
      cut = $urandom_range(1, bytes.size());
      while (bytes.size() > cut) void'(bytes.pop_back());
    end
    foreach (bytes[i]) send_row(pr(bytes[i], i == bytes.size() - 1));
  endtask

  // Result side: random stall bursts while idling is enabled.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      pop <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 7);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // Compare every popped byte with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (expected_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("unexpected item: byte=%h last=%b", out_byte_o, out_last_o);
        end
      end else begin
        want = expected_q.pop_front();
        if (out_byte_o !== want.data || out_last_o !== want.last) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("mismatch: expected byte=%h last=%b, got byte=%h last=%b",
                     want.data, want.last, out_byte_o, out_last_o);
          end
        end
      end
    end
  end

  // Main sequence.
  initial begin
    stim_row_t dir_rows[$];
    int        next_drain;
    // Letters at the edges of the ASCII range and the byte extremes.
    dir_rows.insert(dir_rows.size(), ty(UpperA, 1'b0, 1, 8'h61, 1'b0));
    dir_rows.insert(dir_rows.size(), ty(UpperZ, 1'b0, 1, 8'h7A, 1'b0));
    dir_rows.insert(dir_rows.size(), ty(8'hFF, 1'b0, 1, 8'hFF, 1'b0));
    dir_rows.insert(dir_rows.size(), ty(8'h01, 1'b1, 1, 8'h01, 1'b1));
    // A percent sign on the last byte, then one directly before the last.
    dir_rows.insert(dir_rows.size(), ty(PctChar, 1'b1, 1, PctChar, 1'b1));
    dir_rows.insert(dir_rows.size(), ty(PctChar, 1'b0, 0));
    dir_rows.insert(dir_rows.size(), ty(8'h51, 1'b1, 2, PctChar, 1'b0, 8'h71, 1'b1));
    // A decoded zero in mid-name ends it; the rest of the name is dropped.
    dir_rows.insert(dir_rows.size(), ty(PctChar, 1'b0, 0));
    dir_rows.insert(dir_rows.size(), ty(8'h30, 1'b0, 0));
    dir_rows.insert(dir_rows.size(), ty(8'h30, 1'b0, 1, 8'h00, 1'b1));
    dir_rows.insert(dir_rows.size(), ty(8'h61, 1'b0, 0));
    dir_rows.insert(dir_rows.size(), ty(8'h62, 1'b1, 0));
    // An escaped lead byte folds the raw byte after it.
    dir_rows.insert(dir_rows.size(), pr(PctChar, 1'b0));
    dir_rows.insert(dir_rows.size(), pr(8'h63, 1'b0));
    dir_rows.insert(dir_rows.size(), pr(8'h33, 1'b0));
    dir_rows.insert(dir_rows.size(), pr(LatinLow, 1'b0));
    // Raw lead bytes: top of the folded range, then an ASCII letter left alone.
    dir_rows.insert(dir_rows.size(), pr(LeadByte, 1'b0));
    dir_rows.insert(dir_rows.size(), pr(LatinHigh, 1'b0));
    dir_rows.insert(dir_rows.size(), pr(LeadByte, 1'b0));
    dir_rows.insert(dir_rows.size(), pr(UpperA, 1'b1));
    // Digits that are not hex are reduced all the same.
    dir_rows.insert(dir_rows.size(), pr(PctChar, 1'b0));
    dir_rows.insert(dir_rows.size(), pr(8'h67, 1'b0));
    dir_rows.insert(dir_rows.size(), pr(PctChar, 1'b0));
    // A lead byte followed by a decoded zero on the last byte.
    dir_rows.insert(dir_rows.size(), pr(LeadByte, 1'b0));
    dir_rows.insert(dir_rows.size(), pr(PctChar, 1'b0));
    dir_rows.insert(dir_rows.size(), pr(8'h30, 1'b0));
    dir_rows.insert(dir_rows.size(), pr(8'h30, 1'b1));

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) send_row(dir_rows[i]);
    wait_drained();

    // Random names, with a full drain now and then and a calm stretch at the end.
    next_drain = live_items + DrainEvery;
    while (live_items < NumItems) begin
      if (live_items >= NumItems - CalmItems) idle_on = 1'b0;
      if (live_items >= next_drain) begin
        wait_drained();
        next_drain += DrainEvery;
      end
      send_name();
    end
    wait_drained();
    repeat (10) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("tb_percent_decode_latin_lowercase_top: PASS");
    end else begin
      $display("tb_percent_decode_latin_lowercase_top: FAIL");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5000000;
    $display("tb_percent_decode_latin_lowercase_top: FAIL");
    $finish;
  end

endmodule
